// ----- rtl/biquad_filter_dry_wet_mix_macros.svh -----
// ----------------------------------------------------------------------------
// Biquad dry/wet mix assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_FILTER_DRY_WET_MIX_MACROS_SVH
`define BIQUAD_FILTER_DRY_WET_MIX_MACROS_SVH

// implication checked in the next cycle, masked while in reset
`define BQMIX_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// implication checked in the next cycle, also across reset
`define BQMIX_ASSERT_NEXT_ALWAYS(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bqmix_pkg.sv -----
// ----------------------------------------------------------------------------
// Biquad dry/wet mix package
// Widths, register indexes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package bqmix_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int GAIN_W    = 16;
    localparam int FRAC_BITS = COEF_W - 2;
    localparam int MIX_FRAC  = 15;

    // multiplier operands: a is coefficient or sample, b is sample or gain
    localparam int A_W    = (COEF_W > SAMPLE_W) ? COEF_W : SAMPLE_W;
    localparam int B_W    = (SAMPLE_W > GAIN_W + 1) ? SAMPLE_W : GAIN_W + 1;
    localparam int PROD_W = A_W + B_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int CFG_W  = (COEF_W > GAIN_W) ? COEF_W : GAIN_W;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0] DRY_GAIN_RST = GAIN_W'(32768);

    typedef enum logic [2:0] {
        REG_B0  = 3'd0,
        REG_B1  = 3'd1,
        REG_B2  = 3'd2,
        REG_A1  = 3'd3,
        REG_A2  = 3'd4,
        REG_DRY = 3'd5,
        REG_WET = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        TAP_B0,
        TAP_B1,
        TAP_B2,
        TAP_A1,
        TAP_A2,
        TAP_DRY
    } tap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_WET,
        ST_MIX
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_LOAD
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        logic    sub;
        acc_op_t acc_op;
    } mac_ctrl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/bqmix_mac.sv -----
// ----------------------------------------------------------------------------
// Biquad dry/wet mix multiply-accumulate unit
// One registered signed multiplier feeding an add/subtract accumulator.
// ----------------------------------------------------------------------------
module bqmix_mac
    import bqmix_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [A_W-1:0]   op_a,
    input  logic signed [B_W-1:0]   op_b,
    input  mac_ctrl_t               ctrl,
    output logic signed [ACC_W-1:0] acc,
    output logic signed [ACC_W-1:0] sum
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);
    assign sum      = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
    assign acc      = acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
            sub_reg  <= ctrl.sub;
        end
        case (ctrl.acc_op)
            ACC_CLEAR: acc_reg <= '0;
            ACC_ADD:   acc_reg <= sum;
            ACC_LOAD:  acc_reg <= prod_ext;
            default:   acc_reg <= acc_reg;
        endcase
    end

endmodule

// ----- rtl/biquad_filter_dry_wet_mix.sv -----
// ----------------------------------------------------------------------------
// Biquad filter with dry/wet mix
// Direct form I biquad on signed samples followed by a saturated dry/wet mix.
// ----------------------------------------------------------------------------
// After a sample is accepted, one 18x17 multiplier and accumulator are stepped
// through the five filter taps and the two mix gains, then a round state
// rounds the filter output and a mix state rounds the mix into the output
// register; no new sample is taken until it is idle again. s_ready is high
// only while the sequencer is idle. A clear command (s_command = 1) zeroes the
// filter history on acceptance and produces no result. The result register
// may still hold an earlier sample while the next one is being computed;
// the sequencer waits for it only when the new result is due.
module biquad_filter_dry_wet_mix
    import bqmix_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_command,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    localparam logic signed [ACC_W-1:0] RND_Y   = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_MIX = ACC_W'(1) << (MIX_FRAC - 1);

    logic signed [COEF_W-1:0]   coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEF_W-1:0]   coef_a1_reg, coef_a2_reg;
    logic [GAIN_W-1:0]          dry_gain_reg, wet_gain_reg;

    logic signed [SAMPLE_W-1:0] x_reg, x1_reg, x2_reg, y1_reg, y2_reg, y_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                       out_vld_reg;

    state_t                     state_reg, state_next;
    tap_t                       tap_reg, tap_next;

    mac_ctrl_t                  mac_ctrl;
    logic signed [A_W-1:0]      op_a;
    logic signed [B_W-1:0]      op_b;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    sum;
    logic signed [ACC_W-1:0]    y_shift, mix_shift;
    logic signed [SAMPLE_W-1:0] y_sat, mix_sat;
    logic                       s_xfer, out_free;

    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !out_vld_reg || m_ready;
    assign y_shift   = (acc + RND_Y) >>> FRAC_BITS;
    assign y_sat     = sat_sample(y_shift);
    assign mix_shift = (sum + RND_MIX) >>> MIX_FRAC;
    assign mix_sat   = sat_sample(mix_shift);

    assign m_valid      = out_vld_reg;
    assign m_sample_out = out_reg;

    bqmix_mac u_mac (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .ctrl (mac_ctrl),
        .acc  (acc),
        .sum  (sum)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        tap_next   = tap_reg;
        case (state_reg)
            ST_IDLE: begin
                tap_next = TAP_B0;
                if (s_xfer && !s_command) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                tap_next = tap_t'(tap_reg + 3'd1);
                if (tap_reg == TAP_DRY) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_WET;
            ST_WET:   state_next = ST_MIX;
            ST_MIX: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and operand selection
    always_comb begin
        s_ready         = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.sub    = 1'b0;
        mac_ctrl.acc_op = ACC_HOLD;
        op_a            = A_W'(x_reg);
        op_b            = B_W'($signed({1'b0, dry_gain_reg}));
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_MAC: begin
                mac_ctrl.mul_en = 1'b1;
                // product of the previous tap lands this cycle
                mac_ctrl.acc_op = (tap_reg == TAP_B0) ? ACC_CLEAR : ACC_ADD;
                case (tap_reg)
                    TAP_B0: begin
                        op_a = A_W'(coef_b0_reg);
                        op_b = B_W'(x_reg);
                    end
                    TAP_B1: begin
                        op_a = A_W'(coef_b1_reg);
                        op_b = B_W'(x1_reg);
                    end
                    TAP_B2: begin
                        op_a = A_W'(coef_b2_reg);
                        op_b = B_W'(x2_reg);
                    end
                    TAP_A1: begin
                        op_a         = A_W'(coef_a1_reg);
                        op_b         = B_W'(y1_reg);
                        mac_ctrl.sub = 1'b1;
                    end
                    TAP_A2: begin
                        op_a         = A_W'(coef_a2_reg);
                        op_b         = B_W'(y2_reg);
                        mac_ctrl.sub = 1'b1;
                    end
                    default: begin
                        op_a = A_W'(x_reg);
                        op_b = B_W'($signed({1'b0, dry_gain_reg}));
                    end
                endcase
            end
            // filter sum is complete; start the mix with the dry product
            ST_ROUND: mac_ctrl.acc_op = ACC_LOAD;
            ST_WET: begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = A_W'(y_reg);
                op_b            = B_W'($signed({1'b0, wet_gain_reg}));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tap_reg      <= TAP_B0;
            out_vld_reg  <= 1'b0;
            coef_b0_reg  <= '0;
            coef_b1_reg  <= '0;
            coef_b2_reg  <= '0;
            coef_a1_reg  <= '0;
            coef_a2_reg  <= '0;
            dry_gain_reg <= DRY_GAIN_RST;
            wet_gain_reg <= '0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            y1_reg       <= '0;
            y2_reg       <= '0;
        end else begin
            state_reg <= state_next;
            tap_reg   <= tap_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_B0:  coef_b0_reg  <= cfg_wr_data[COEF_W-1:0];
                    REG_B1:  coef_b1_reg  <= cfg_wr_data[COEF_W-1:0];
                    REG_B2:  coef_b2_reg  <= cfg_wr_data[COEF_W-1:0];
                    REG_A1:  coef_a1_reg  <= cfg_wr_data[COEF_W-1:0];
                    REG_A2:  coef_a2_reg  <= cfg_wr_data[COEF_W-1:0];
                    REG_DRY: dry_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                    REG_WET: wet_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (s_xfer && s_command) begin
                x1_reg <= '0;
                x2_reg <= '0;
                y1_reg <= '0;
                y2_reg <= '0;
            end else if (state_reg == ST_ROUND) begin
                x2_reg <= x1_reg;
                x1_reg <= x_reg;
                y2_reg <= y1_reg;
                y1_reg <= y_sat;
            end

            if (state_reg == ST_MIX && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == ST_ROUND) begin
            y_reg <= y_sat;
        end
        if (state_reg == ST_MIX && out_free) begin
            out_reg <= mix_sat;
        end
    end

endmodule

// ----- rtl/bqmix_checker.sv -----
// ----------------------------------------------------------------------------
// Biquad dry/wet mix port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "biquad_filter_dry_wet_mix_macros.svh"

module bqmix_checker
    import bqmix_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_command,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [SAMPLE_W-1:0] m_sample_out
);

    // a sample transfer keeps the sequencer busy for the next cycle
    `BQMIX_ASSERT_NEXT(a_busy_after_sample, s_valid && s_ready && !s_command, !s_ready, "ready stayed high after a sample transfer")

    // a clear finishes at once and creates no result
    `BQMIX_ASSERT_NEXT(a_clear_no_result, s_valid && s_ready && s_command, s_ready && !$rose(m_valid), "clear transfer produced a result or stalled")

    // a stalled result holds
    `BQMIX_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_sample_out), "stalled result changed or dropped")

    `BQMIX_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

endmodule

bind biquad_filter_dry_wet_mix bqmix_checker u_bqmix_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_command    (s_command),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);
